[rtl/core/sfh_pkg.sv]
// Shared types and constants for the supervisory frame handshake block.
// Used by sfh_ctrl, sfh_emit and supervisory_frame_handshake; depends on nothing.
package sfh_pkg;

	localparam logic [7:0] FRAME_FLAG = 8'h7E;
	localparam logic [2:0] LAST_IDX = 3'd4;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_RX = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [1:0] REG_ADDRESS = 2'd0;
	localparam logic [1:0] REG_CONTROL = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;
	localparam logic [1:0] REG_RETRY_LIMIT = 2'd3;

	localparam logic [7:0] RST_ADDRESS = 8'h01;
	localparam logic [7:0] RST_CONTROL = 8'h03;
	localparam logic [15:0] RST_TIMEOUT = 16'd3;
	localparam logic [3:0] RST_RETRY_LIMIT = 4'd3;
	localparam logic [3:0] MAX_COUNT = 4'd15;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT,
		PH_MATCHED,
		PH_FAILED
	} phase_t;

	typedef enum logic [2:0] {
		MS_HUNT,
		MS_FLAG,
		MS_ADDR,
		MS_CTRL,
		MS_CHECK
	} match_t;

	typedef enum logic [1:0] {
		RK_TX,
		RK_MATCHED,
		RK_FAILED
	} res_kind_t;

	typedef struct packed {
		logic       req;
		res_kind_t  kind;
		logic [7:0] addr_byte;
		logic [7:0] ctrl_byte;
	} burst_t;

endpackage

[rtl/core/sfh_ctrl.sv]
// Handshake protocol state: phase, reply matcher, tick and timeout counters.
// Decides which result burst a request causes; depends on sfh_pkg.
module sfh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [1:0]          opcode,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          address_byte,
	input  logic [7:0]          control_byte,
	input  logic [15:0]         timeout_ticks,
	input  logic [3:0]          retry_limit,
	output sfh_pkg::burst_t     burst
);
	import sfh_pkg::*;

	phase_t      phase_q, phase_d;
	match_t      match_q, match_d;
	logic [3:0]  used_q, used_d;
	logic [15:0] tick_q, tick_d;

	logic [15:0] limit;
	logic [3:0]  allowed;
	logic [15:0] tick_inc;
	logic [3:0]  used_inc;
	logic [7:0]  check_byte;

	assign limit = (timeout_ticks == '0) ? 16'd1 : timeout_ticks;
	assign allowed = (retry_limit == '0) ? 4'd1 : retry_limit;
	assign tick_inc = tick_q + 16'd1;
	assign used_inc = (used_q < MAX_COUNT) ? used_q + 4'd1 : used_q;
	assign check_byte = address_byte ^ control_byte;

	always_comb begin
		phase_d = phase_q;
		match_d = match_q;
		used_d = used_q;
		tick_d = tick_q;
		burst.req = 1'b0;
		burst.kind = RK_TX;
		burst.addr_byte = address_byte;
		burst.ctrl_byte = control_byte;
		case (opcode)
			OP_START: begin
				used_d = '0;
				tick_d = '0;
				phase_d = PH_WAIT;
				match_d = MS_HUNT;
				burst.req = 1'b1;
			end
			OP_RX: begin
				if (phase_q == PH_WAIT) begin
					case (match_q)
						MS_FLAG: begin
							if (rx_byte == FRAME_FLAG) match_d = MS_FLAG;
							else if (rx_byte == address_byte) match_d = MS_ADDR;
							else match_d = MS_HUNT;
						end
						MS_ADDR: begin
							if (rx_byte == FRAME_FLAG) match_d = MS_FLAG;
							else if (rx_byte == control_byte) match_d = MS_CTRL;
							else match_d = MS_HUNT;
						end
						MS_CTRL: begin
							if (rx_byte == FRAME_FLAG) match_d = MS_FLAG;
							else if (rx_byte == check_byte) match_d = MS_CHECK;
							else match_d = MS_HUNT;
						end
						MS_CHECK: begin
							match_d = MS_HUNT;
							if (rx_byte == FRAME_FLAG) begin
								phase_d = PH_MATCHED;
								burst.req = 1'b1;
								burst.kind = RK_MATCHED;
							end
						end
						default: begin
							match_d = (rx_byte == FRAME_FLAG) ? MS_FLAG : MS_HUNT;
						end
					endcase
				end
			end
			OP_TICK: begin
				if (phase_q == PH_WAIT) begin
					tick_d = tick_inc;
					if (!(tick_inc < limit && tick_inc != '0)) begin
						tick_d = '0;
						used_d = used_inc;
						match_d = MS_HUNT;
						burst.req = 1'b1;
						if (used_inc >= allowed) begin
							phase_d = PH_FAILED;
							burst.kind = RK_FAILED;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			match_q <= MS_HUNT;
			used_q <= '0;
			tick_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			match_q <= match_d;
			used_q <= used_d;
			tick_q <= tick_d;
		end
	end

`ifndef SYNTHESIS
	a_hunt_outside_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_WAIT) |-> (match_q == MS_HUNT))
		else $error("reply matcher active outside an exchange");
	a_fail_burst_sets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && burst.req && burst.kind == RK_FAILED) |=> (phase_q == PH_FAILED))
		else $error("failure reported but phase not failed");
	a_idle_no_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_WAIT && opcode != OP_START) |-> !burst.req)
		else $error("result burst requested outside an exchange");
`endif

endmodule

[rtl/core/sfh_emit.sv]
// Result sequencer: holds one burst and presents its results one per cycle while out_ready is high.
// A frame burst yields five transmit bytes, a status burst a single result; uses sfh_pkg.
module sfh_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  sfh_pkg::burst_t     burst,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          result_kind,
	output logic [7:0]          tx_byte,
	output logic                last
);
	import sfh_pkg::*;

	logic       busy_q;
	res_kind_t  kind_q;
	logic [2:0] idx_q;
	logic [7:0] addr_q;
	logic [7:0] ctrl_q;
	logic       fire;

	assign out_valid = busy_q;
	assign result_kind = kind_q;
	assign last = (kind_q != RK_TX) || (idx_q == LAST_IDX);
	assign fire = busy_q && out_ready;
	assign free = !busy_q || (out_ready && last);

	always_comb begin
		tx_byte = '0;
		if (kind_q == RK_TX) begin
			case (idx_q)
				3'd1: tx_byte = addr_q;
				3'd2: tx_byte = ctrl_q;
				3'd3: tx_byte = addr_q ^ ctrl_q;
				default: tx_byte = FRAME_FLAG;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= RK_TX;
			idx_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			kind_q <= burst.kind;
			idx_q <= '0;
		end else if (fire) begin
			if (last) busy_q <= 1'b0;
			else idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			addr_q <= burst.addr_byte;
			ctrl_q <= burst.ctrl_byte;
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= LAST_IDX))
		else $error("result index beyond frame length");
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && kind_q != RK_TX) |-> (idx_q == '0))
		else $error("status burst advanced past its only result");
	a_frame_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !last) |=> (busy_q && idx_q == $past(idx_q) + 3'd1 && kind_q == RK_TX))
		else $error("frame burst did not step to its next byte");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("burst loaded over one still in flight");
`endif

endmodule

[rtl/core/supervisory_frame_handshake.sv]
// Top level of the supervisory frame handshake, sender side.
// Holds the configuration registers and the request register; uses sfh_pkg, sfh_ctrl, sfh_emit.
//
//   Channel  Signals                              Direction  Moves
//   in       in_valid in_ready opcode rx_byte     sink       one request
//   out      out_valid out_ready result_kind ...  source     one result
//   cfg      cfg_we cfg_index cfg_data            sink       one register write
//
// A request is registered, then resolved in the cycle it leaves the register.
// A request without results does not wait on the sequencer; one that starts or resends a frame
// holds the result sequencer for five transmit bytes, a match or failure for a single result.
// The request register refills while a burst is still being delivered.
// Reset restores the register defaults, idle phase and cleared counters at once.
module supervisory_frame_handshake (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [7:0]  tx_byte,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sfh_pkg::*;

	logic [7:0]  address_q;
	logic [7:0]  control_q;
	logic [15:0] timeout_q;
	logic [3:0]  retry_limit_q;

	logic        valid_s1;
	logic [1:0]  opcode_s1;
	logic [7:0]  rx_byte_s1;

	burst_t      burst;
	logic        free;
	logic        advance;
	logic        load;

	assign advance = valid_s1 && (!burst.req || free);
	assign load = valid_s1 && burst.req && free;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q <= RST_ADDRESS;
			control_q <= RST_CONTROL;
			timeout_q <= RST_TIMEOUT;
			retry_limit_q <= RST_RETRY_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ADDRESS: address_q <= cfg_data[7:0];
				REG_CONTROL: control_q <= cfg_data[7:0];
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_RETRY_LIMIT: retry_limit_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			rx_byte_s1 <= rx_byte;
		end
	end

	sfh_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.opcode        (opcode_s1),
		.rx_byte       (rx_byte_s1),
		.address_byte  (address_q),
		.control_byte  (control_q),
		.timeout_ticks (timeout_q),
		.retry_limit   (retry_limit_q),
		.burst         (burst)
	);

	sfh_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.burst       (burst),
		.free        (free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.tx_byte     (tx_byte),
		.last        (last)
	);

`ifndef SYNTHESIS
	a_load_advances: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> advance)
		else $error("burst loaded without retiring its request");
	a_stalled_request_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(opcode_s1) && $stable(rx_byte_s1)))
		else $error("stalled request register changed");
	a_stall_only_on_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (burst.req && out_valid))
		else $error("request stalled with no burst in flight");
`endif

endmodule

[bench/tb_supervisory_frame_handshake.sv]
`timescale 1ns / 1ps
// Self-checking testbench for supervisory_frame_handshake: drives requests and register
// writes, predicts every transmit, match and give-up result, and checks them in order.
// Depends on sfh_pkg and the supervisory_frame_handshake RTL only.
module tb_supervisory_frame_handshake;
	import sfh_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_PER_PHASE = 62;

	typedef struct packed {
		res_kind_t  kind;
		logic [7:0] octet;
		logic       fin;
	} line_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  opcode;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  result_kind;
	logic [7:0]  tx_byte;
	logic        last;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	logic [7:0]  cfg_addr;
	logic [7:0]  cfg_ctrl;
	logic [15:0] cfg_timeout;
	logic [3:0]  cfg_max;
	phase_t      ph;
	match_t      ms;
	logic [3:0]  tmo_used;
	logic [15:0] tick_cnt;

	line_result_t pending_results[$];
	int errors;
	int useful_cnt;
	int idle_cycles;
	int snd_idle_pct;
	int rcv_stall_pct;

	supervisory_frame_handshake dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.tx_byte(tx_byte),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic void push_result(res_kind_t kind, logic [7:0] octet, logic fin);
		line_result_t r;
		r.kind = kind;
		r.octet = octet;
		r.fin = fin;
		pending_results.push_back(r);
	endfunction

	function automatic void queue_frame();
		push_result(RK_TX, FRAME_FLAG, 1'b0);
		push_result(RK_TX, cfg_addr, 1'b0);
		push_result(RK_TX, cfg_ctrl, 1'b0);
		push_result(RK_TX, cfg_addr ^ cfg_ctrl, 1'b0);
		push_result(RK_TX, FRAME_FLAG, 1'b1);
		ms = MS_HUNT;
	endfunction

	// Returns 1 when the request is acted on rather than ignored.
	function automatic bit advance_link(logic [1:0] op, logic [7:0] b);
		logic [15:0] lim;
		logic [3:0]  allowed;
		if (op == OP_START) begin
			tmo_used = '0;
			tick_cnt = '0;
			ph = PH_WAIT;
			queue_frame();
			return 1'b1;
		end
		if (ph != PH_WAIT) return 1'b0;
		if (op == OP_RX) begin
			case (ms)
				MS_FLAG: begin
					if (b == FRAME_FLAG) ms = MS_FLAG;
					else if (b == cfg_addr) ms = MS_ADDR;
					else ms = MS_HUNT;
				end
				MS_ADDR: begin
					if (b == FRAME_FLAG) ms = MS_FLAG;
					else if (b == cfg_ctrl) ms = MS_CTRL;
					else ms = MS_HUNT;
				end
				MS_CTRL: begin
					if (b == FRAME_FLAG) ms = MS_FLAG;
					else if (b == (cfg_addr ^ cfg_ctrl)) ms = MS_CHECK;
					else ms = MS_HUNT;
				end
				MS_CHECK: begin
					ms = MS_HUNT;
					if (b == FRAME_FLAG) begin
						ph = PH_MATCHED;
						push_result(RK_MATCHED, 8'h00, 1'b1);
					end
				end
				default: begin
					if (b == FRAME_FLAG) ms = MS_FLAG;
					else ms = MS_HUNT;
				end
			endcase
			return 1'b1;
		end
		if (op == OP_TICK) begin
			lim = (cfg_timeout == 16'd0) ? 16'd1 : cfg_timeout;
			allowed = (cfg_max == 4'd0) ? 4'd1 : cfg_max;
			tick_cnt = tick_cnt + 16'd1;
			if (tick_cnt < lim && tick_cnt != 16'd0) return 1'b1;
			tick_cnt = '0;
			if (tmo_used < MAX_COUNT) tmo_used = tmo_used + 4'd1;
			if (tmo_used >= allowed) begin
				ph = PH_FAILED;
				ms = MS_HUNT;
				push_result(RK_FAILED, 8'h00, 1'b1);
			end else begin
				queue_frame();
			end
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic send_req(input logic [1:0] op, input logic [7:0] b);
		while ($urandom_range(99) < snd_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		if (advance_link(op, b)) useful_cnt++;
	endtask

	task automatic send_reply(input bit corrupt, input bit extra_flag);
		logic [7:0] frame [5];
		int pos;
		frame[0] = FRAME_FLAG;
		frame[1] = cfg_addr;
		frame[2] = cfg_ctrl;
		frame[3] = cfg_addr ^ cfg_ctrl;
		frame[4] = FRAME_FLAG;
		if (corrupt) begin
			pos = $urandom_range(4);
			frame[pos] = $urandom_range(255);
		end
		if (extra_flag) send_req(OP_RX, FRAME_FLAG);
		for (int i = 0; i < 5; i++) send_req(OP_RX, frame[i]);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ADDRESS: cfg_addr = val[7:0];
			REG_CONTROL: cfg_ctrl = val[7:0];
			REG_TIMEOUT: cfg_timeout = val;
			REG_RETRY_LIMIT: cfg_max = val[3:0];
			default: begin
			end
		endcase
	endtask

	task automatic set_idling(input int snd, input int rcv);
		snd_idle_pct = snd;
		rcv_stall_pct = rcv;
	endtask

	always @(negedge clk) out_ready <= ($urandom_range(99) >= rcv_stall_pct);

	always @(posedge clk) begin
		line_result_t exp_r;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: result_kind %0d tx_byte %02h last %0d",
					result_kind, tx_byte, last);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result_kind !== exp_r.kind) begin
					$error("result_kind expected %0d actual %0d", exp_r.kind, result_kind);
					errors++;
				end
				if (tx_byte !== exp_r.octet) begin
					$error("tx_byte expected %02h actual %02h", exp_r.octet, tx_byte);
					errors++;
				end
				if (last !== exp_r.fin) begin
					$error("last expected %0d actual %0d", exp_r.fin, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Reset values drive the first exchange: two resends, then the give-up.
	task automatic test_reset_defaults();
		send_req(OP_TICK, 8'h00);
		send_req(OP_RX, FRAME_FLAG);
		send_req(OP_UNUSED, 8'hFF);
		send_req(OP_START, 8'hA5);
		repeat (9) send_req(OP_TICK, 8'h5A);
		send_req(OP_TICK, 8'h00);
		wait_idle();
	endtask

	// Flag restarts, fall-back to hunting, a bad byte after the check byte, then a match.
	task automatic test_reply_matching();
		write_reg(REG_ADDRESS, 16'h12C4);
		write_reg(REG_CONTROL, 16'hED3B);
		send_req(OP_START, 8'h00);
		send_req(OP_RX, FRAME_FLAG);
		send_req(OP_RX, FRAME_FLAG);
		send_req(OP_RX, 8'hC4);
		send_req(OP_RX, 8'h00);
		send_req(OP_RX, FRAME_FLAG);
		send_req(OP_RX, 8'hC4);
		send_req(OP_RX, 8'h3B);
		send_req(OP_RX, 8'hC4 ^ 8'h3B);
		send_req(OP_RX, 8'h55);
		send_reply(1'b0, 1'b0);
		send_req(OP_RX, FRAME_FLAG);
		send_req(OP_START, 8'h00);
		wait_idle();
	endtask

	// Flag-valued fields can never match; zero registers act as one; full-scale timeout.
	task automatic test_register_extremes();
		write_reg(REG_ADDRESS, 16'hC37E);
		write_reg(REG_CONTROL, 16'h5AFF);
		write_reg(REG_TIMEOUT, 16'h0000);
		write_reg(REG_RETRY_LIMIT, 16'hFFF0);
		send_req(OP_START, 8'h00);
		send_reply(1'b0, 1'b1);
		send_req(OP_TICK, 8'h00);
		wait_idle();
		write_reg(REG_ADDRESS, 16'h00FF);
		write_reg(REG_CONTROL, 16'hA57E);
		write_reg(REG_TIMEOUT, 16'hFFFF);
		write_reg(REG_RETRY_LIMIT, 16'h000F);
		send_req(OP_START, 8'h00);
		send_reply(1'b0, 1'b0);
		send_req(OP_TICK, 8'h00);
		send_req(OP_TICK, 8'h00);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int target;
		int r;
		int sel;
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: set_idling(0, 0);
				1: set_idling(78, 0);
				2: set_idling(0, 78);
				default: set_idling(16, 16);
			endcase
			wait_idle();
			r = $urandom_range(255);
			write_reg(REG_ADDRESS, {r[7:0], ($urandom_range(9) == 0) ? FRAME_FLAG
				: 8'($urandom_range(255))});
			r = $urandom_range(255);
			write_reg(REG_CONTROL, {r[7:0], ($urandom_range(9) == 0) ? FRAME_FLAG
				: 8'($urandom_range(255))});
			sel = $urandom_range(9);
			if (k == 0 || sel == 0) write_reg(REG_TIMEOUT, 16'h0000);
			else if (sel == 1) write_reg(REG_TIMEOUT, 16'hFFFF);
			else write_reg(REG_TIMEOUT, 16'($urandom_range(1, 5)));
			sel = $urandom_range(9);
			r = $urandom_range(4095);
			if (sel == 0) write_reg(REG_RETRY_LIMIT, {r[11:0], 4'h0});
			else if (k == 0 || sel == 1) write_reg(REG_RETRY_LIMIT, {r[11:0], 4'hF});
			else write_reg(REG_RETRY_LIMIT, {r[11:0], 4'($urandom_range(1, 4))});
			target = useful_cnt + RANDOM_PER_PHASE;
			while (useful_cnt < target) begin
				r = $urandom_range(99);
				if (ph != PH_WAIT && $urandom_range(99) < 80) begin
					send_req(OP_START, 8'($urandom_range(255)));
				end else if (r < 8) begin
					send_req(OP_START, 8'($urandom_range(255)));
				end else if (r < 55) begin
					send_reply($urandom_range(99) < 25, $urandom_range(99) < 15);
				end else if (r < 80) begin
					repeat ($urandom_range(1, 3)) send_req(OP_TICK, 8'($urandom_range(255)));
				end else if (r < 95) begin
					send_req(OP_RX, 8'($urandom_range(255)));
				end else begin
					send_req(2'($urandom_range(3)), 8'($urandom_range(255)));
				end
			end
			wait_idle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_START;
		rx_byte = 8'h00;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ADDRESS;
		cfg_data = 16'h0000;
		cfg_addr = RST_ADDRESS;
		cfg_ctrl = RST_CONTROL;
		cfg_timeout = RST_TIMEOUT;
		cfg_max = RST_RETRY_LIMIT;
		ph = PH_IDLE;
		ms = MS_HUNT;
		tmo_used = '0;
		tick_cnt = '0;
		errors = 0;
		useful_cnt = 0;
		idle_cycles = 0;
		set_idling(0, 0);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_reply_matching();
		test_register_extremes();
		test_random_traffic();
		wait_idle();

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/sfh_pkg.sv
rtl/core/sfh_ctrl.sv
rtl/core/sfh_emit.sv
rtl/core/supervisory_frame_handshake.sv
bench/tb_supervisory_frame_handshake.sv
